/* src/lpd_pkg.sv */
`default_nettype none

package lpd_pkg;

   localparam int DEF_NUM_CHANNELS = 16;
   localparam int DEF_HEADER_BYTES = 4;

   localparam int REQ_Q_DEPTH = 2;
   localparam int RSP_Q_DEPTH = 4;
   localparam int RSP_CNT_W   = $clog2(RSP_Q_DEPTH + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH = 2'd1;

   localparam logic [30:0] MAX_LENGTH_RESET = 31'd65536;

   typedef struct packed {
      logic [3:0] channel;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  out_channel;
      logic [7:0]  payload_byte;
      logic        frame_first;
      logic        frame_last;
      logic        empty_frame;
      logic [30:0] frame_length;
      logic        length_error;
   } rsp_type;

endpackage

`default_nettype wire

/* src/lpd_fifo.sv */
`default_nettype none

module lpd_fifo #(
   parameter int WIDTH = $bits(lpd_pkg::rsp_type),
   parameter int DEPTH = lpd_pkg::RSP_Q_DEPTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire logic [WIDTH-1:0]             wdata,
   input  wire logic                         pop,
   output logic      [WIDTH-1:0]             rdata,
   output logic                              full,
   output logic                              empty,
   output logic      [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign count   = cnt_ff;
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         cnt_in = CW'(cnt_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         cnt_in = CW'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

/* src/lpd_front.sv */
`default_nettype none

module lpd_front #(
   parameter int NUM_CHANNELS = lpd_pkg::DEF_NUM_CHANNELS
) (
   input  wire logic             req_push,
   input  wire lpd_pkg::req_type req_item,
   output logic                  req_full,
   input  wire logic             enable,
   input  wire logic             init_done,
   input  wire logic             q_full,
   output logic                  q_push,
   output lpd_pkg::req_type      q_item
);

   logic accept;
   logic keep;

   assign req_full = !init_done || q_full;
   assign accept   = req_push && !req_full;
   // drop bytes while disabled and bytes of channels that do not exist
   assign keep     = enable && ({28'd0, req_item.channel} < 32'(NUM_CHANNELS));
   assign q_push   = accept && keep;
   assign q_item   = req_item;

endmodule

`default_nettype wire

/* src/lpd_back.sv */
`default_nettype none

module lpd_back #(
   parameter int NUM_CHANNELS = lpd_pkg::DEF_NUM_CHANNELS,
   parameter int HEADER_BYTES = lpd_pkg::DEF_HEADER_BYTES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [30:0]                   max_length,
   input  wire logic                          q_empty,
   input  wire lpd_pkg::req_type              q_item,
   output logic                               q_pop,
   input  wire logic [lpd_pkg::RSP_CNT_W-1:0] rsp_count,
   output logic                               rsp_push,
   output lpd_pkg::rsp_type                   rsp_data,
   output logic                               init_done
);

   localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CLW = $clog2(NUM_CHANNELS + 1);
   localparam int CW  = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
   localparam int LW  = 8 * HEADER_BYTES;
   localparam int CRW = lpd_pkg::RSP_CNT_W + 1;

   typedef struct packed {
      logic [CW-1:0] hcnt;
      logic [LW-1:0] word;
      logic [30:0]   left;
   } ctx_type;

   ctx_type          ctx_mem_ff [NUM_CHANNELS];
   ctx_type          rd_ctx_ff;
   ctx_type          fwd_ctx_ff;
   logic             fwd_ff, fwd_in;
   logic             s1_vld_ff;
   lpd_pkg::req_type s1_item_ff;
   logic [CLW-1:0]   init_cnt_ff;

   ctx_type          cur, nxt;
   lpd_pkg::rsp_type res;
   logic             has_res;
   logic [LW-1:0]    nw;
   logic [63:0]      len64;
   logic [30:0]      cur_len;

   logic             mem_we;
   logic [CHW-1:0]   mem_wa;
   ctx_type          mem_wd;

   assign init_done = (init_cnt_ff == CLW'(NUM_CHANNELS));

   // reserve a result slot for every transaction in flight
   assign q_pop = init_done && !q_empty &&
                  ((CRW'(rsp_count) + CRW'(s1_vld_ff)) < CRW'(lpd_pkg::RSP_Q_DEPTH));

   assign fwd_in = s1_vld_ff && q_pop && (q_item.channel == s1_item_ff.channel);

   always_comb begin
      cur     = fwd_ff ? fwd_ctx_ff : rd_ctx_ff;
      nxt     = cur;
      res     = '0;
      res.out_channel = s1_item_ff.channel;
      has_res = 1'b0;
      cur_len = 31'(cur.word);
      nw      = (cur.hcnt == '0) ? '0 : cur.word;
      for (int k = 0; k < HEADER_BYTES; k++) begin
         if (cur.hcnt == CW'(k)) begin
            nw[8*k +: 8] = s1_item_ff.data_byte;
         end
      end
      len64 = 64'(nw);
      if (cur.left != '0) begin
         has_res            = 1'b1;
         res.payload_byte   = s1_item_ff.data_byte;
         res.frame_first    = (cur.left == cur_len);
         res.frame_last     = (cur.left == 31'd1);
         res.frame_length   = cur_len;
         nxt.left           = cur.left - 31'd1;
      end else if (cur.hcnt != CW'(HEADER_BYTES - 1)) begin
         nxt.hcnt = CW'(cur.hcnt + 1'b1);
         nxt.word = nw;
      end else begin
         nxt.hcnt = '0;
         if (len64 > 64'(max_length)) begin
            has_res            = 1'b1;
            res.length_error   = 1'b1;
            res.frame_length   = (len64[63:31] != '0) ? '1 : len64[30:0];
            nxt.word           = '0;
         end else if (len64 == '0) begin
            has_res            = 1'b1;
            res.frame_last     = 1'b1;
            res.empty_frame    = 1'b1;
            nxt.word           = nw;
         end else begin
            nxt.left = len64[30:0];
            nxt.word = nw;
         end
      end
   end

   assign rsp_push = s1_vld_ff && has_res;
   assign rsp_data = res;

   always_comb begin
      if (!init_done) begin
         mem_we = 1'b1;
         mem_wa = init_cnt_ff[CHW-1:0];
         mem_wd = '0;
      end else begin
         mem_we = s1_vld_ff;
         mem_wa = CHW'(s1_item_ff.channel);
         mem_wd = nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ctx_mem_ff[mem_wa] <= mem_wd;
      end
      rd_ctx_ff <= ctx_mem_ff[CHW'(q_item.channel)];
   end

   always_ff @(posedge clock) begin
      fwd_ctx_ff <= nxt;
      s1_item_ff <= q_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         fwd_ff      <= 1'b0;
         init_cnt_ff <= '0;
      end else begin
         s1_vld_ff <= q_pop;
         fwd_ff    <= fwd_in;
         if (!init_done) begin
            init_cnt_ff <= CLW'(init_cnt_ff + 1'b1);
         end
      end
   end

`ifndef SYNTHESIS
   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> (rsp_count < lpd_pkg::RSP_CNT_W'(lpd_pkg::RSP_Q_DEPTH)))
      else $error("result queue overrun");
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      !init_done |-> !q_pop)
      else $error("transaction taken during context clear");
   a_fwd_src: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> (s1_vld_ff && $past(s1_vld_ff)))
      else $error("bypass without producing transaction");
   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && init_done && cur.left != '0) |-> (cur.left <= cur_len))
      else $error("bytes left exceeds frame length");
`endif

endmodule

`default_nettype wire

/* src/length_prefix_deframer_core.sv */
// Length-prefixed stream deframer with one context per channel.
// Input queue port: drive req_channel, req_data_byte, req_chunk_end with req_push;
// a byte is taken at a clock edge with req_push high and req_full low.
// Result queue port: while rsp_empty is low the oldest result is on the rsp_ ports;
// it is removed at a clock edge with rsp_pop high.
// Configuration: csr_index/csr_wdata with csr_valid; csr_ready is always high.
// Index 0 is enable, index 1 is max_length; other indexes are ignored.
// Throughput: one byte per cycle, sustained, on any mix of channels, while the receiver pops results.
// A result reaches the rsp_ ports through the context memory read register
// and then the context update stage, which pushes it into the result queue.
// After reset the context memory is cleared one channel per cycle, so
// req_full stays high until every channel is cleared; csr writes are taken meanwhile.
// A stalled receiver fills the four-entry result queue, the update stage then
// holds, the two-entry input queue fills and req_full rises; nothing is lost.
`default_nettype none

module length_prefix_deframer_core #(
   parameter int NUM_CHANNELS = lpd_pkg::DEF_NUM_CHANNELS,
   parameter int HEADER_BYTES = lpd_pkg::DEF_HEADER_BYTES
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [3:0]                     req_channel,
   input  wire logic [7:0]                     req_data_byte,
   input  wire logic                           req_chunk_end,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic      [3:0]                     rsp_out_channel,
   output logic      [7:0]                     rsp_payload_byte,
   output logic                                rsp_frame_first,
   output logic                                rsp_frame_last,
   output logic                                rsp_empty_frame,
   output logic      [30:0]                    rsp_frame_length,
   output logic                                rsp_length_error,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [lpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lpd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic             enable_ff;
   logic [30:0]      max_length_ff;

   lpd_pkg::req_type req_item;
   lpd_pkg::req_type q_in, q_out;
   logic             q_push, q_pop, q_full, q_empty;
   logic             init_done;

   logic                          rsp_push;
   lpd_pkg::rsp_type              rsp_in, rsp_out;
   logic [lpd_pkg::RSP_CNT_W-1:0] rsp_count;
   logic                          rsp_full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         max_length_ff <= lpd_pkg::MAX_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lpd_pkg::CSR_ENABLE:     enable_ff     <= csr_wdata[0];
            lpd_pkg::CSR_MAX_LENGTH: max_length_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign req_item.channel   = req_channel;
   assign req_item.data_byte = req_data_byte;

   lpd_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .enable    (enable_ff),
      .init_done (init_done),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_in)
   );

   lpd_fifo #(
      .WIDTH ($bits(lpd_pkg::req_type)),
      .DEPTH (lpd_pkg::REQ_Q_DEPTH)
   ) u_req_q (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_in),
      .pop   (q_pop),
      .rdata (q_out),
      .full  (q_full),
      .empty (q_empty),
      .count ()
   );

   lpd_back #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .max_length (max_length_ff),
      .q_empty    (q_empty),
      .q_item     (q_out),
      .q_pop      (q_pop),
      .rsp_count  (rsp_count),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_in),
      .init_done  (init_done)
   );

   lpd_fifo #(
      .WIDTH ($bits(lpd_pkg::rsp_type)),
      .DEPTH (lpd_pkg::RSP_Q_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_in),
      .pop   (rsp_pop),
      .rdata (rsp_out),
      .full  (rsp_full),
      .empty (rsp_empty),
      .count (rsp_count)
   );

   assign rsp_out_channel  = rsp_out.out_channel;
   assign rsp_payload_byte = rsp_out.payload_byte;
   assign rsp_frame_first  = rsp_out.frame_first;
   assign rsp_frame_last   = rsp_out.frame_last;
   assign rsp_empty_frame  = rsp_out.empty_frame;
   assign rsp_frame_length = rsp_out.frame_length;
   assign rsp_length_error = rsp_out.length_error;

`ifndef SYNTHESIS
   a_rsp_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_full |-> !rsp_push)
      else $error("result dropped on full queue");
   a_chunk_ignored: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && !enable_ff) |=> !rsp_push)
      else $error("result from a dropped byte");
   a_full_in_clear: assert property (@(posedge clock) disable iff (reset)
      !init_done |-> (req_full && !req_chunk_end) || req_full)
      else $error("input open during context clear");
`endif

endmodule

`default_nettype wire

/* test/length_prefix_deframer_core_tb.sv */
module length_prefix_deframer_core_tb;
   import lpd_pkg::*;

   localparam int NCH = DEF_NUM_CHANNELS;
   localparam int HDR_BYTES = DEF_HEADER_BYTES;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_B = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 10;

   class deframe_scoreboard;
      logic        enable;
      logic [30:0] max_len;
      logic [2:0]  hdr_count [NCH];
      logic [31:0] len_word  [NCH];
      logic [31:0] remaining [NCH];
      rsp_type     expected_rsp [$];
      int          mismatches;

      function new();
         enable = 1'b0;
         max_len = MAX_LENGTH_RESET;
         mismatches = 0;
         foreach (hdr_count[i]) begin
            hdr_count[i] = '0;
            len_word[i] = '0;
            remaining[i] = '0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ENABLE:     enable = data[0];
            CSR_MAX_LENGTH: max_len = data[30:0];
            default:        ;
         endcase
      endfunction

      function void note_byte(logic [3:0] ch, logic [7:0] b);
         rsp_type r;
         r = '0;
         r.out_channel = ch;
         if (!enable) return;
         if (remaining[ch] != 0) begin
            r.payload_byte = b;
            r.frame_first = (remaining[ch] == len_word[ch]);
            r.frame_last = (remaining[ch] == 32'd1);
            r.frame_length = len_word[ch][30:0];
            remaining[ch] = remaining[ch] - 32'd1;
            expected_rsp.push_back(r);
            return;
         end
         if (hdr_count[ch] == 0) len_word[ch] = '0;
         len_word[ch] = len_word[ch] | ({24'd0, b} << (8 * hdr_count[ch]));
         hdr_count[ch] = hdr_count[ch] + 3'd1;
         if (hdr_count[ch] < HDR_BYTES) return;
         hdr_count[ch] = '0;
         if (len_word[ch] > {1'b0, max_len}) begin
            r.frame_length = len_word[ch][31] ? '1 : len_word[ch][30:0];
            r.length_error = 1'b1;
            len_word[ch] = '0;
            expected_rsp.push_back(r);
         end else if (len_word[ch] == 0) begin
            r.frame_last = 1'b1;
            r.empty_frame = 1'b1;
            expected_rsp.push_back(r);
         end else begin
            remaining[ch] = len_word[ch];
         end
      endfunction

      function string show(rsp_type r);
         return $sformatf("ch=%0d byte=%02h first=%0b last=%0b empty=%0b len=%0d err=%0b",
                          r.out_channel, r.payload_byte, r.frame_first, r.frame_last,
                          r.empty_frame, r.frame_length, r.length_error);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %s", show(got));
            return;
         end
         want = expected_rsp.pop_front();
         if (got.out_channel !== want.out_channel || got.payload_byte !== want.payload_byte ||
             got.frame_first !== want.frame_first || got.frame_last !== want.frame_last ||
             got.empty_frame !== want.empty_frame || got.frame_length !== want.frame_length ||
             got.length_error !== want.length_error) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %s, got %s", show(want), show(got));
         end
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [3:0]            req_channel = '0;
   logic [7:0]            req_data_byte = '0;
   logic                  req_chunk_end = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [3:0]            rsp_out_channel;
   logic [7:0]            rsp_payload_byte;
   logic                  rsp_frame_first;
   logic                  rsp_frame_last;
   logic                  rsp_empty_frame;
   logic [30:0]           rsp_frame_length;
   logic                  rsp_length_error;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rsp_type           rsp_seen;
   deframe_scoreboard sb = new();
   bit                steady = 1'b0;
   int                total_sent = 0;
   int                cycle_count = 0;
   logic [30:0]       cur_max = MAX_LENGTH_RESET;
   logic [7:0]        pend [NCH][$];

   assign rsp_seen = {rsp_out_channel, rsp_payload_byte, rsp_frame_first, rsp_frame_last,
                      rsp_empty_frame, rsp_frame_length, rsp_length_error};

   length_prefix_deframer_core u_top (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_push && !req_full) sb.note_byte(req_channel, req_data_byte);
      if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) sb.check_result(rsp_seen);
         rsp_pop <= steady || ($urandom_range(99) >= 17);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("length_prefix_deframer_core_tb failed");
         $finish;
      end
   end

   function automatic logic [31:0] enable_word(bit on);
      return ($urandom & 32'hFFFF_FFFE) | {31'd0, on};
   endfunction

   function automatic int pend_total();
      int t;
      t = 0;
      for (int c = 0; c < NCH; c++) t += pend[c].size();
      return t;
   endfunction

   // Build one header plus payload for a channel, sized against the current max length.
   function automatic void queue_frame(logic [3:0] ch, bit noisy);
      logic [31:0] len;
      logic [31:0] lim;
      int          kind;
      int          n_pay;
      kind = $urandom_range(99);
      lim = (cur_max < 31'd24) ? {1'b0, cur_max} : 32'd24;
      if (kind < 2) begin
         len = '1;
      end else if (kind < 12) begin
         if (cur_max == '1 || kind < 5) len = $urandom | 32'h8000_0000;
         else len = {1'b0, cur_max} + 32'($urandom_range(4, 1));
      end else if (kind < 22 || cur_max == 0) begin
         len = '0;
      end else if (kind < 30 && cur_max <= 31'd300) begin
         len = {1'b0, cur_max};
      end else begin
         len = $urandom_range(lim, 1);
      end
      for (int i = 0; i < HDR_BYTES; i++) pend[ch].push_back(len[8*i +: 8]);
      n_pay = (len != 0 && len <= {1'b0, cur_max}) ? int'(len) : 0;
      // truncate now and then to knock the channel out of step
      if (noisy && n_pay > 1 && $urandom_range(99) < 8) n_pay = $urandom_range(n_pay - 1);
      repeat (n_pay) pend[ch].push_back(8'($urandom));
   endfunction

   task automatic push_byte(input logic [3:0] ch, input logic [7:0] b);
      while (!steady && $urandom_range(99) < 17) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_channel <= ch;
      req_data_byte <= b;
      req_chunk_end <= 1'($urandom_range(1));
      total_sent++;
      steady <= (total_sent >= 700 && total_sent < 1100);
      do @(posedge clock); while (req_full);
   endtask

   task automatic send_word(input logic [3:0] ch, input logic [31:0] w);
      for (int i = 0; i < HDR_BYTES; i++) push_byte(ch, w[8*i +: 8]);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_config(input logic [31:0] en_data, input logic [31:0] max_data);
      write_csr(CSR_UNUSED_A, $urandom);
      write_csr(CSR_ENABLE, en_data);
      write_csr(CSR_MAX_LENGTH, max_data);
      write_csr(CSR_UNUSED_B, $urandom);
      csr_valid <= 1'b0;
      cur_max = max_data[30:0];
   endtask

   // Hold until every expected transaction has arrived, then let the pipeline settle.
   task automatic drain();
      req_push <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int n_items, input bit noisy, input bit raw);
      logic [3:0] ch;
      int         sent;
      sent = 0;
      while (sent < n_items) begin
         ch = 4'($urandom_range(NCH - 1));
         if (raw || (noisy && $urandom_range(99) < 4)) begin
            push_byte(ch, 8'($urandom));
         end else begin
            if (pend[ch].size() == 0) queue_frame(ch, noisy);
            push_byte(ch, pend[ch].pop_front());
         end
         sent++;
      end
      while (pend_total() != 0) begin
         ch = 4'($urandom_range(NCH - 1));
         if (pend[ch].size() != 0) push_byte(ch, pend[ch].pop_front());
      end
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      apply_config(enable_word(1'b1), {1'b0, MAX_LENGTH_RESET});

      send_word(4'd0, 32'd0);
      send_word(4'd15, 32'd2);
      push_byte(4'd15, 8'hFF);
      push_byte(4'd15, 8'h00);
      send_word(4'd12, 32'hFFFF_FFFF);
      send_word(4'd5, 32'h0001_0001);
      send_word(4'd9, 32'd3);
      push_byte(4'd9, 8'hA5);
      drain();
      apply_config(enable_word(1'b0), {1'b0, MAX_LENGTH_RESET});
      push_byte(4'd9, 8'h5A);
      push_byte(4'd9, 8'h3C);
      drain();
      apply_config(enable_word(1'b1), {1'b0, MAX_LENGTH_RESET});
      push_byte(4'd9, 8'h5A);
      push_byte(4'd9, 8'hC3);
      drain();

      apply_config(enable_word(1'b1), 32'hFFFF_FFFF);
      run_phase(290, 1'b0, 1'b0);
      apply_config(enable_word(1'b1), 32'h8000_0003);
      run_phase(250, 1'b1, 1'b0);
      apply_config(enable_word(1'b1), 32'h8000_0000);
      run_phase(140, 1'b1, 1'b0);
      apply_config(enable_word(1'b0), $urandom);
      run_phase(60, 1'b0, 1'b1);
      apply_config(enable_word(1'b1), 32'($urandom_range(40, 1)));
      run_phase(290, 1'b1, 1'b0);
      apply_config(enable_word(1'b1), {1'b0, MAX_LENGTH_RESET});
      run_phase(320, 1'b1, 1'b0);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("length_prefix_deframer_core_tb passed");
      end else begin
         $display("length_prefix_deframer_core_tb failed");
      end
      $finish;
   end
endmodule
